[src/closest_point_on_triangle_top_defines.svh]
// Assertion macros shared by the closest-point pipeline.
`ifndef CLOSEST_POINT_ON_TRIANGLE_TOP_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CPT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Fixed-latency implication.
`define CPT_ASSERT_LATENCY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

[src/cpt_pkg.sv]
// Shared constants for the closest-point-on-triangle block.
`timescale 1ns / 1ps

package cpt_pkg;

    // Region codes
    localparam logic [2:0] REGION_A        = 3'd0;
    localparam logic [2:0] REGION_B        = 3'd1;
    localparam logic [2:0] REGION_AB       = 3'd2;
    localparam logic [2:0] REGION_C        = 3'd3;
    localparam logic [2:0] REGION_AC       = 3'd4;
    localparam logic [2:0] REGION_BC       = 3'd5;
    localparam logic [2:0] REGION_INTERIOR = 3'd6;

    // Q1.16 weights
    localparam int         WEIGHT_W  = 17;
    localparam int         FRAC_BITS = 16;
    localparam logic [16:0] ONE_Q    = 17'h10000;

endpackage

[src/closest_point_on_triangle_top.sv]
// Closest point on a triangle with Voronoi region classification, fully pipelined.
`timescale 1ns / 1ps

// One query transaction enters per cycle on start; busy is always low and results
// leave on done in order. The pipeline holds a 16-stage restoring divider (one
// quotient bit per stage) plus thirteen other stages for differences, dot products,
// cross products (two stages), barycentric numerators, region selection, denominator
// sign, divider setup, point reconstruction and distance. The receiver cannot stall;
// a result is present for one cycle only. Coordinates are signed Q16.16, weights
// unsigned Q1.16, dist_squared unsigned Q32.32 saturating at all ones.

`include "closest_point_on_triangle_top_defines.svh"

module closest_point_on_triangle_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic signed [COORD_WIDTH-1:0] query_z,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] closest_x,
    output logic signed [COORD_WIDTH-1:0] closest_y,
    output logic signed [COORD_WIDTH-1:0] closest_z,
    output logic [16:0]                   weight_a,
    output logic [16:0]                   weight_b,
    output logic [16:0]                   weight_c,
    output logic [2:0]                    region,
    output logic [63:0]                   dist_squared,
    output logic                          degenerate
);

    localparam int W   = COORD_WIDTH;
    localparam int PW  = 2 * W + 2;        // edge-by-offset product
    localparam int DW  = 2 * W + 4;        // dot product
    localparam int XW  = 2 * DW;           // cross term
    localparam int HB  = DW / 2;           // low half of a dot product
    localparam int PPW = 2 * HB + 2;       // cross-term partial product
    localparam int VW  = XW + 1;           // barycentric numerator
    localparam int NW  = VW + 3;           // divider operand
    localparam int QB  = cpt_pkg::FRAC_BITS;
    localparam int MW  = W + 19;           // edge times weight
    localparam int SW  = W + 20;           // reconstructed point sum
    localparam int SQW = 2 * W + 2;
    localparam int DSW = 2 * W + 4;
    localparam int SXW = (DSW > 64) ? DSW : 65;
    localparam int NS  = 13 + QB;          // pipeline depth
    localparam int CRN = QB + 3;           // carry stages from region select to divider end

    typedef struct packed {
        logic [2:0][W-1:0] a;
        logic [2:0][W-1:0] b;
        logic [2:0][W-1:0] c;
        logic [2:0][W-1:0] p;
        logic [2:0][W:0]   ab;
        logic [2:0][W:0]   ac;
        logic [2:0][W:0]   bc;
    } geo_t;

    typedef struct packed {
        logic [2:0][W-1:0] base;
        logic [2:0][W:0]   e1;
        logic [2:0][W:0]   e2;
        logic [2:0][W-1:0] p;
        logic [2:0]        region;
        logic              degen;
    } carry_t;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [NW-1:0] den;
        logic [QB-1:0] q;
        logic          fixed;
        logic [16:0]   fixval;
    } div_t;

    typedef struct packed {
        logic [PPW-1:0] hh;
        logic [PPW-1:0] hl;
        logic [PPW-1:0] lh;
        logic [PPW-1:0] ll;
    } pp_t;

    // One restoring division step
    function automatic div_t div_step(input div_t s);
        logic [NW:0] sh;
        logic [NW:0] diff;
        div_t        r;
        sh   = {s.rem, 1'b0};
        diff = sh - {1'b0, s.den};
        r    = s;
        if (sh >= {1'b0, s.den})
        begin
            r.rem = diff[NW-1:0];
            r.q   = {s.q[QB-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh[NW-1:0];
            r.q   = {s.q[QB-2:0], 1'b0};
        end
        return r;
    endfunction

    // Never stalls
    assign busy = 1'b0;

    // Valid bits travel alongside the payload
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    assign vld_next = {vld_reg[NS-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- stage 1: edge and offset vectors ----------------
    logic signed [W-1:0] in_a [3];
    logic signed [W-1:0] in_b [3];
    logic signed [W-1:0] in_c [3];
    logic signed [W-1:0] in_p [3];
    assign in_a[0] = vertex_a_x;
    assign in_a[1] = vertex_a_y;
    assign in_a[2] = vertex_a_z;
    assign in_b[0] = vertex_b_x;
    assign in_b[1] = vertex_b_y;
    assign in_b[2] = vertex_b_z;
    assign in_c[0] = vertex_c_x;
    assign in_c[1] = vertex_c_y;
    assign in_c[2] = vertex_c_z;
    assign in_p[0] = query_x;
    assign in_p[1] = query_y;
    assign in_p[2] = query_z;

    geo_t              geo_next;
    geo_t              geo_reg [0:5];
    logic signed [W:0] ap_next [3];
    logic signed [W:0] bp_next [3];
    logic signed [W:0] cp_next [3];
    logic signed [W:0] s1_ap_reg [3];
    logic signed [W:0] s1_bp_reg [3];
    logic signed [W:0] s1_cp_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            geo_next.a[k]  = in_a[k];
            geo_next.b[k]  = in_b[k];
            geo_next.c[k]  = in_c[k];
            geo_next.p[k]  = in_p[k];
            geo_next.ab[k] = (W+1)'(in_b[k]) - (W+1)'(in_a[k]);
            geo_next.ac[k] = (W+1)'(in_c[k]) - (W+1)'(in_a[k]);
            geo_next.bc[k] = (W+1)'(in_c[k]) - (W+1)'(in_b[k]);
            ap_next[k]     = (W+1)'(in_p[k]) - (W+1)'(in_a[k]);
            bp_next[k]     = (W+1)'(in_p[k]) - (W+1)'(in_b[k]);
            cp_next[k]     = (W+1)'(in_p[k]) - (W+1)'(in_c[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        geo_reg[0] <= geo_next;
        for (int j = 1; j < 6; j++)
        begin
            geo_reg[j] <= geo_reg[j-1];
        end
        for (int k = 0; k < 3; k++)
        begin
            s1_ap_reg[k] <= ap_next[k];
            s1_bp_reg[k] <= bp_next[k];
            s1_cp_reg[k] <= cp_next[k];
        end
    end

    // ---------------- stage 2: per-axis products ----------------
    // order: d1 ab.ap, d2 ac.ap, d3 ab.bp, d4 ac.bp, d5 ab.cp, d6 ac.cp
    logic signed [PW-1:0] pr_next [6][3];
    logic signed [PW-1:0] s2_pr_reg [6][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pr_next[0][k] = $signed(geo_reg[0].ab[k]) * s1_ap_reg[k];
            pr_next[1][k] = $signed(geo_reg[0].ac[k]) * s1_ap_reg[k];
            pr_next[2][k] = $signed(geo_reg[0].ab[k]) * s1_bp_reg[k];
            pr_next[3][k] = $signed(geo_reg[0].ac[k]) * s1_bp_reg[k];
            pr_next[4][k] = $signed(geo_reg[0].ab[k]) * s1_cp_reg[k];
            pr_next[5][k] = $signed(geo_reg[0].ac[k]) * s1_cp_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_pr_reg <= pr_next;
    end

    // ---------------- stage 3: dot products ----------------
    logic signed [DW-1:0] d_next [6];
    logic signed [DW-1:0] s3_d_reg [6];
    logic signed [DW-1:0] s4p_d_reg [6];
    logic signed [DW-1:0] s4_d_reg [6];
    logic signed [DW-1:0] s5_d_reg [6];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            d_next[i] = DW'(s2_pr_reg[i][0]) + DW'(s2_pr_reg[i][1]) + DW'(s2_pr_reg[i][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        s3_d_reg  <= d_next;
        s4p_d_reg <= s3_d_reg;
        s4_d_reg  <= s4p_d_reg;
        s5_d_reg  <= s4_d_reg;
    end

    // ---------------- stage 4a: cross-term partial products ----------------
    // Each operand splits into a signed high half and an unsigned low half
    function automatic pp_t mul_parts(input logic signed [DW-1:0] x,
                                      input logic signed [DW-1:0] y);
        logic signed [HB-1:0]  xh, yh;
        logic signed [HB:0]    xl, yl;
        logic signed [PPW-1:0] phh, phl, plh, pll;
        pp_t                   r;
        xh   = x[DW-1:HB];
        yh   = y[DW-1:HB];
        xl   = {1'b0, x[HB-1:0]};
        yl   = {1'b0, y[HB-1:0]};
        phh  = xh * yh;
        phl  = xh * yl;
        plh  = xl * yh;
        pll  = xl * yl;
        r.hh = phh;
        r.hl = phl;
        r.lh = plh;
        r.ll = pll;
        return r;
    endfunction

    pp_t pp_next [6];
    pp_t s4p_pp_reg [6];

    always_comb
    begin
        pp_next[0] = mul_parts(s3_d_reg[0], s3_d_reg[3]);  // d1*d4
        pp_next[1] = mul_parts(s3_d_reg[2], s3_d_reg[1]);  // d3*d2
        pp_next[2] = mul_parts(s3_d_reg[4], s3_d_reg[1]);  // d5*d2
        pp_next[3] = mul_parts(s3_d_reg[0], s3_d_reg[5]);  // d1*d6
        pp_next[4] = mul_parts(s3_d_reg[2], s3_d_reg[5]);  // d3*d6
        pp_next[5] = mul_parts(s3_d_reg[4], s3_d_reg[3]);  // d5*d4
    end

    always_ff @(posedge clk)
    begin
        s4p_pp_reg <= pp_next;
    end

    // ---------------- stage 4b: cross terms ----------------
    function automatic logic signed [XW-1:0] mul_join(input pp_t s);
        logic signed [XW-1:0] th, tm, tl;
        th = XW'($signed(s.hh));
        tm = XW'($signed(s.hl)) + XW'($signed(s.lh));
        tl = XW'($signed(s.ll));
        return (th <<< (2 * HB)) + (tm <<< HB) + tl;
    endfunction

    logic signed [XW-1:0] x_next [6];
    logic signed [XW-1:0] s4_x_reg [6];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            x_next[i] = mul_join(s4p_pp_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        s4_x_reg <= x_next;
    end

    // ---------------- stage 5: barycentric numerators ----------------
    logic signed [VW-1:0] vc_next, vb_next, va_next;
    logic signed [NW-1:0] den_next;
    logic signed [DW:0]   e43_next, e56_next, d13_next, d26_next;
    logic signed [DW+1:0] ebc_next;
    logic signed [VW-1:0] s5_vc_reg, s5_vb_reg, s5_va_reg;
    logic signed [NW-1:0] s5_den_reg;
    logic signed [DW:0]   s5_e43_reg, s5_e56_reg, s5_d13_reg, s5_d26_reg;
    logic signed [DW+1:0] s5_ebc_reg;

    always_comb
    begin
        vc_next  = VW'(s4_x_reg[0]) - VW'(s4_x_reg[1]);
        vb_next  = VW'(s4_x_reg[2]) - VW'(s4_x_reg[3]);
        va_next  = VW'(s4_x_reg[4]) - VW'(s4_x_reg[5]);
        den_next = NW'(va_next) + NW'(vb_next) + NW'(vc_next);
        e43_next = (DW+1)'(s4_d_reg[3]) - (DW+1)'(s4_d_reg[2]);
        e56_next = (DW+1)'(s4_d_reg[4]) - (DW+1)'(s4_d_reg[5]);
        d13_next = (DW+1)'(s4_d_reg[0]) - (DW+1)'(s4_d_reg[2]);
        d26_next = (DW+1)'(s4_d_reg[1]) - (DW+1)'(s4_d_reg[5]);
        ebc_next = (DW+2)'(e43_next) + (DW+2)'(e56_next);
    end

    always_ff @(posedge clk)
    begin
        s5_vc_reg  <= vc_next;
        s5_vb_reg  <= vb_next;
        s5_va_reg  <= va_next;
        s5_den_reg <= den_next;
        s5_e43_reg <= e43_next;
        s5_e56_reg <= e56_next;
        s5_d13_reg <= d13_next;
        s5_d26_reg <= d26_next;
        s5_ebc_reg <= ebc_next;
    end

    // ---------------- stage 6: region select ----------------
    carry_t               cr_next;
    carry_t               cr_reg [0:CRN-1];
    logic signed [NW-1:0] na_next, da_next, nb_next, db_next;
    logic signed [NW-1:0] s6_na_reg, s6_da_reg, s6_nb_reg, s6_db_reg;
    logic signed [DW-1:0] d1, d2, d3, d4, d5, d6;

    assign d1 = s5_d_reg[0];
    assign d2 = s5_d_reg[1];
    assign d3 = s5_d_reg[2];
    assign d4 = s5_d_reg[3];
    assign d5 = s5_d_reg[4];
    assign d6 = s5_d_reg[5];

    always_comb
    begin
        cr_next.base   = geo_reg[5].a;
        cr_next.e1     = '0;
        cr_next.e2     = '0;
        cr_next.p      = geo_reg[5].p;
        cr_next.region = cpt_pkg::REGION_INTERIOR;
        cr_next.degen  = 1'b0;
        na_next        = '0;
        da_next        = NW'(1);
        nb_next        = '0;
        db_next        = NW'(1);
        priority if (d1 <= 0 && d2 <= 0)
        begin
            cr_next.region = cpt_pkg::REGION_A;
        end
        else if (d3 >= 0 && d4 <= d3)
        begin
            cr_next.region = cpt_pkg::REGION_B;
            cr_next.base   = geo_reg[5].b;
        end
        else if (s5_vc_reg <= 0 && d1 >= 0 && d3 <= 0)
        begin
            cr_next.region = cpt_pkg::REGION_AB;
            cr_next.e1     = geo_reg[5].ab;
            na_next        = NW'(d1);
            da_next        = NW'(s5_d13_reg);
        end
        else if (d6 >= 0 && d5 <= d6)
        begin
            cr_next.region = cpt_pkg::REGION_C;
            cr_next.base   = geo_reg[5].c;
        end
        else if (s5_vb_reg <= 0 && d2 >= 0 && d6 <= 0)
        begin
            cr_next.region = cpt_pkg::REGION_AC;
            cr_next.e1     = geo_reg[5].ac;
            na_next        = NW'(d2);
            da_next        = NW'(s5_d26_reg);
        end
        else if (s5_va_reg <= 0 && s5_e43_reg >= 0 && s5_e56_reg >= 0)
        begin
            cr_next.region = cpt_pkg::REGION_BC;
            cr_next.base   = geo_reg[5].b;
            cr_next.e1     = geo_reg[5].bc;
            na_next        = NW'(s5_e43_reg);
            da_next        = NW'(s5_ebc_reg);
        end
        else if (s5_den_reg == 0)
        begin
            cr_next.degen = 1'b1;
        end
        else
        begin
            cr_next.e1 = geo_reg[5].ab;
            cr_next.e2 = geo_reg[5].ac;
            na_next    = NW'(s5_vb_reg);
            da_next    = s5_den_reg;
            nb_next    = NW'(s5_vc_reg);
            db_next    = s5_den_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cr_reg[0] <= cr_next;
        for (int j = 1; j < CRN; j++)
        begin
            cr_reg[j] <= cr_reg[j-1];
        end
        s6_na_reg <= na_next;
        s6_da_reg <= da_next;
        s6_nb_reg <= nb_next;
        s6_db_reg <= db_next;
    end

    // ---------------- stage 7: make denominators positive ----------------
    logic signed [NW-1:0] s7_na_reg, s7_da_reg, s7_nb_reg, s7_db_reg;
    logic signed [NW-1:0] na7_next, da7_next, nb7_next, db7_next;

    always_comb
    begin
        na7_next = (s6_da_reg < 0) ? -s6_na_reg : s6_na_reg;
        da7_next = (s6_da_reg < 0) ? -s6_da_reg : s6_da_reg;
        nb7_next = (s6_db_reg < 0) ? -s6_nb_reg : s6_nb_reg;
        db7_next = (s6_db_reg < 0) ? -s6_db_reg : s6_db_reg;
    end

    always_ff @(posedge clk)
    begin
        s7_na_reg <= na7_next;
        s7_da_reg <= da7_next;
        s7_nb_reg <= nb7_next;
        s7_db_reg <= db7_next;
    end

    // ---------------- stage 8: divider setup ----------------
    div_t lane_a_reg [0:QB];
    div_t lane_b_reg [0:QB];
    div_t la_next, lb_next;

    function automatic div_t div_init(input logic signed [NW-1:0] n,
                                      input logic signed [NW-1:0] d);
        div_t r;
        r.rem    = n;
        r.den    = d;
        r.q      = '0;
        r.fixed  = 1'b0;
        r.fixval = '0;
        priority if (d == 0 || n <= 0)
        begin
            r.fixed = 1'b1;
        end
        else if (n >= d)
        begin
            r.fixed  = 1'b1;
            r.fixval = cpt_pkg::ONE_Q;
        end
        else
        begin
            r.fixed = 1'b0;
        end
        return r;
    endfunction

    assign la_next = div_init(s7_na_reg, s7_da_reg);
    assign lb_next = div_init(s7_nb_reg, s7_db_reg);

    // setup, then stages 9..24: one quotient bit per stage
    always_ff @(posedge clk)
    begin
        lane_a_reg[0] <= la_next;
        lane_b_reg[0] <= lb_next;
        for (int i = 0; i < QB; i++)
        begin
            lane_a_reg[i+1] <= div_step(lane_a_reg[i]);
            lane_b_reg[i+1] <= div_step(lane_b_reg[i]);
        end
    end

    // ---------------- stage 25: edge times weight ----------------
    logic [16:0]          f1_next, f2_next;
    logic [16:0]          s25_f1_reg, s25_f2_reg;
    logic signed [MW-1:0] m1_next [3];
    logic signed [MW-1:0] m2_next [3];
    logic signed [MW-1:0] s25_m1_reg [3];
    logic signed [MW-1:0] s25_m2_reg [3];
    carry_t               s25_cr_reg;

    always_comb
    begin
        f1_next = lane_a_reg[QB].fixed ? lane_a_reg[QB].fixval : {1'b0, lane_a_reg[QB].q};
        f2_next = lane_b_reg[QB].fixed ? lane_b_reg[QB].fixval : {1'b0, lane_b_reg[QB].q};
        for (int k = 0; k < 3; k++)
        begin
            m1_next[k] = $signed(cr_reg[CRN-1].e1[k]) * $signed({1'b0, f1_next});
            m2_next[k] = $signed(cr_reg[CRN-1].e2[k]) * $signed({1'b0, f2_next});
        end
    end

    always_ff @(posedge clk)
    begin
        s25_f1_reg <= f1_next;
        s25_f2_reg <= f2_next;
        s25_m1_reg <= m1_next;
        s25_m2_reg <= m2_next;
        s25_cr_reg <= cr_reg[CRN-1];
    end

    // ---------------- stage 26: reconstruct point, weights ----------------
    logic signed [SW-1:0] sum_pt  [3];
    logic signed [SW-1:0] pt_full [3];
    logic [2:0][W-1:0]    q_next;
    logic [2:0][W-1:0]    s26_q_reg;
    logic [2:0][W-1:0]    s26_p_reg;
    logic [16:0]          wa_next, wb_next, wc_next;
    logic [16:0]          s26_wa_reg, s26_wb_reg, s26_wc_reg;
    logic [17:0]          vw_sum;
    logic [2:0]           s26_region_reg;
    logic                 s26_degen_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum_pt[k]  = SW'(s25_m1_reg[k]) + SW'(s25_m2_reg[k]);
            pt_full[k] = (sum_pt[k] >>> QB) + SW'($signed(s25_cr_reg.base[k]));
            // saturate to the coordinate range
            if (pt_full[k][SW-1:W-1] == '0 || pt_full[k][SW-1:W-1] == '1)
            begin
                q_next[k] = pt_full[k][W-1:0];
            end
            else if (pt_full[k][SW-1])
            begin
                q_next[k] = {1'b1, {(W-1){1'b0}}};
            end
            else
            begin
                q_next[k] = {1'b0, {(W-1){1'b1}}};
            end
        end

        vw_sum = {1'b0, s25_f1_reg} + {1'b0, s25_f2_reg};
        wa_next = cpt_pkg::ONE_Q;
        wb_next = '0;
        wc_next = '0;
        unique case (s25_cr_reg.region)
            cpt_pkg::REGION_A:
            begin
                wa_next = cpt_pkg::ONE_Q;
            end
            cpt_pkg::REGION_B:
            begin
                wa_next = '0;
                wb_next = cpt_pkg::ONE_Q;
            end
            cpt_pkg::REGION_AB:
            begin
                wa_next = cpt_pkg::ONE_Q - s25_f1_reg;
                wb_next = s25_f1_reg;
            end
            cpt_pkg::REGION_C:
            begin
                wa_next = '0;
                wc_next = cpt_pkg::ONE_Q;
            end
            cpt_pkg::REGION_AC:
            begin
                wa_next = cpt_pkg::ONE_Q - s25_f1_reg;
                wc_next = s25_f1_reg;
            end
            cpt_pkg::REGION_BC:
            begin
                wa_next = '0;
                wb_next = cpt_pkg::ONE_Q - s25_f1_reg;
                wc_next = s25_f1_reg;
            end
            cpt_pkg::REGION_INTERIOR:
            begin
                if (!s25_cr_reg.degen)
                begin
                    wa_next = (vw_sum > 18'(cpt_pkg::ONE_Q)) ? 17'd0
                            : 17'(18'(cpt_pkg::ONE_Q) - vw_sum);
                    wb_next = s25_f1_reg;
                    wc_next = s25_f2_reg;
                end
            end
            default:
            begin
                wa_next = cpt_pkg::ONE_Q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s26_q_reg      <= q_next;
        s26_p_reg      <= s25_cr_reg.p;
        s26_wa_reg     <= wa_next;
        s26_wb_reg     <= wb_next;
        s26_wc_reg     <= wc_next;
        s26_region_reg <= s25_cr_reg.region;
        s26_degen_reg  <= s25_cr_reg.degen;
    end

    // ---------------- stage 27: squared axis distances ----------------
    logic signed [W:0]     dd     [3];
    logic signed [SQW-1:0] sq_next [3];
    logic [SQW-1:0]        s27_sq_reg [3];
    logic [2:0][W-1:0]     s27_q_reg;
    logic [16:0]           s27_wa_reg, s27_wb_reg, s27_wc_reg;
    logic [2:0]            s27_region_reg;
    logic                  s27_degen_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dd[k]      = (W+1)'($signed(s26_q_reg[k])) - (W+1)'($signed(s26_p_reg[k]));
            sq_next[k] = dd[k] * dd[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s27_sq_reg[k] <= sq_next[k];
        end
        s27_q_reg      <= s26_q_reg;
        s27_wa_reg     <= s26_wa_reg;
        s27_wb_reg     <= s26_wb_reg;
        s27_wc_reg     <= s26_wc_reg;
        s27_region_reg <= s26_region_reg;
        s27_degen_reg  <= s26_degen_reg;
    end

    // ---------------- stage 28: distance sum and output registers ----------------
    logic [DSW-1:0]    dsum;
    logic [SXW-1:0]    dsum_x;
    logic [63:0]       dist_next;
    logic [2:0][W-1:0] out_q_reg;
    logic [16:0]       out_wa_reg, out_wb_reg, out_wc_reg;
    logic [2:0]        out_region_reg;
    logic [63:0]       out_dist_reg;
    logic              out_degen_reg;

    always_comb
    begin
        dsum      = DSW'(s27_sq_reg[0]) + DSW'(s27_sq_reg[1]) + DSW'(s27_sq_reg[2]);
        dsum_x    = SXW'(dsum);
        dist_next = (|dsum_x[SXW-1:64]) ? '1 : dsum_x[63:0];
    end

    always_ff @(posedge clk)
    begin
        out_q_reg      <= s27_q_reg;
        out_wa_reg     <= s27_wa_reg;
        out_wb_reg     <= s27_wb_reg;
        out_wc_reg     <= s27_wc_reg;
        out_region_reg <= s27_region_reg;
        out_dist_reg   <= dist_next;
        out_degen_reg  <= s27_degen_reg;
    end

    assign done         = vld_reg[NS-1];
    assign closest_x    = out_q_reg[0];
    assign closest_y    = out_q_reg[1];
    assign closest_z    = out_q_reg[2];
    assign weight_a     = out_wa_reg;
    assign weight_b     = out_wb_reg;
    assign weight_c     = out_wc_reg;
    assign region       = out_region_reg;
    assign dist_squared = out_dist_reg;
    assign degenerate   = out_degen_reg;

    // ---------------- assertions ----------------
    `CPT_ASSERT_LATENCY(a_latency, start && !busy, NS, done, "accepted transaction lost")
    `CPT_ASSERT_IMPLIES(a_degen_shape, done && degenerate,
        region == cpt_pkg::REGION_INTERIOR && weight_a == cpt_pkg::ONE_Q,
        "degenerate result has wrong region or weight")
    `CPT_ASSERT_IMPLIES(a_weight_sum, done && region != cpt_pkg::REGION_INTERIOR,
        19'(weight_a) + 19'(weight_b) + 19'(weight_c) == 19'(cpt_pkg::ONE_Q),
        "boundary weights do not sum to one")

endmodule

[sim/tb.sv]
// Self-checking testbench for closest_point_on_triangle_top with a built-in predictor.
`timescale 1ns / 1ps

module tb;

    localparam int CW = 32;
    localparam int LATENCY = 29;
    localparam int WATCHDOG = 20000;
    localparam logic [16:0] Q_ONE = cpt_pkg::ONE_Q;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz;
    } tri_query_t;

    typedef struct packed {
        logic [CW-1:0] x, y, z;
        logic [16:0]   wa, wb, wc;
        logic [2:0]    reg_code;
        logic [63:0]   dsq;
        logic          degen;
    } nearest_t;

    logic clk, rst_n, start, busy, done;
    tri_query_t q_in;
    logic signed [CW-1:0] closest_x, closest_y, closest_z;
    logic [16:0] weight_a, weight_b, weight_c;
    logic [2:0] region;
    logic [63:0] dist_squared;
    logic degenerate;

    nearest_t pending_answers[$];
    int mismatches, sent, received, idle_cycles, region_hits[7];
    int send_gap_pct;
    bit timed_out;

    closest_point_on_triangle_top #(.COORD_WIDTH(CW)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .vertex_a_x(q_in.ax), .vertex_a_y(q_in.ay), .vertex_a_z(q_in.az),
        .vertex_b_x(q_in.bx), .vertex_b_y(q_in.by), .vertex_b_z(q_in.bz),
        .vertex_c_x(q_in.cx), .vertex_c_y(q_in.cy), .vertex_c_z(q_in.cz),
        .query_x(q_in.px), .query_y(q_in.py), .query_z(q_in.pz),
        .done(done), .closest_x(closest_x), .closest_y(closest_y),
        .closest_z(closest_z), .weight_a(weight_a), .weight_b(weight_b),
        .weight_c(weight_c), .region(region), .dist_squared(dist_squared),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Q1.16 quotient, truncated and clamped to 0..1
    function automatic logic [16:0] q16_ratio(wide_t num, wide_t den);
        wide_t n, d;
        n = num;
        d = den;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        if (d == 0 || n <= 0) return 17'd0;
        if (n >= d) return Q_ONE;
        return 17'((n <<< 16) / d);
    endfunction

    function automatic wide_t dot(wide_t u0, wide_t u1, wide_t u2,
                                  wide_t v0, wide_t v1, wide_t v2);
        return u0 * v0 + u1 * v1 + u2 * v2;
    endfunction

    function automatic wide_t clamp_coord(wide_t v);
        wide_t lo, hi;
        lo = -(wide_t'(1) <<< (CW - 1));
        hi = (wide_t'(1) <<< (CW - 1)) - 1;
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic nearest_t pack_answer(wide_t x, wide_t y, wide_t z,
            wide_t p0, wide_t p1, wide_t p2, logic [16:0] wa, logic [16:0] wb,
            logic [16:0] wc, logic [2:0] rc, logic dg);
        nearest_t r;
        wide_t sx, sy, sz, s;
        sx = clamp_coord(x);
        sy = clamp_coord(y);
        sz = clamp_coord(z);
        s = (sx - p0) * (sx - p0) + (sy - p1) * (sy - p1) + (sz - p2) * (sz - p2);
        r.x = sx[CW-1:0];
        r.y = sy[CW-1:0];
        r.z = sz[CW-1:0];
        r.wa = wa;
        r.wb = wb;
        r.wc = wc;
        r.reg_code = rc;
        r.dsq = (s[255:64] != 0) ? '1 : s[63:0];
        r.degen = dg;
        return r;
    endfunction

    // Voronoi-region classification and closest point, exact wide arithmetic
    function automatic nearest_t predict_nearest(tri_query_t t);
        wide_t a[3], b[3], c[3], p[3], ab[3], ac[3], ap[3], bp[3], cp[3], pt[3];
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e43, e56, den;
        logic [16:0] v, w, wa;
        a = '{t.ax, t.ay, t.az};
        b = '{t.bx, t.by, t.bz};
        c = '{t.cx, t.cy, t.cz};
        p = '{t.px, t.py, t.pz};
        for (int k = 0; k < 3; k++)
        begin
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
        end
        d1 = dot(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
        d2 = dot(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
        if (d1 <= 0 && d2 <= 0)
            return pack_answer(a[0], a[1], a[2], p[0], p[1], p[2], Q_ONE, 0, 0,
                               cpt_pkg::REGION_A, 0);
        d3 = dot(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
        d4 = dot(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
        if (d3 >= 0 && d4 <= d3)
            return pack_answer(b[0], b[1], b[2], p[0], p[1], p[2], 0, Q_ONE, 0,
                               cpt_pkg::REGION_B, 0);
        vc = d1 * d4 - d3 * d2;
        if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            v = q16_ratio(d1, d1 - d3);
            for (int k = 0; k < 3; k++) pt[k] = a[k] + ((ab[k] * wide_t'(v)) >>> 16);
            return pack_answer(pt[0], pt[1], pt[2], p[0], p[1], p[2],
                               Q_ONE - v, v, 0, cpt_pkg::REGION_AB, 0);
        end
        d5 = dot(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
        d6 = dot(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
        if (d6 >= 0 && d5 <= d6)
            return pack_answer(c[0], c[1], c[2], p[0], p[1], p[2], 0, 0, Q_ONE,
                               cpt_pkg::REGION_C, 0);
        vb = d5 * d2 - d1 * d6;
        if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            w = q16_ratio(d2, d2 - d6);
            for (int k = 0; k < 3; k++) pt[k] = a[k] + ((ac[k] * wide_t'(w)) >>> 16);
            return pack_answer(pt[0], pt[1], pt[2], p[0], p[1], p[2],
                               Q_ONE - w, 0, w, cpt_pkg::REGION_AC, 0);
        end
        va = d3 * d6 - d5 * d4;
        e43 = d4 - d3;
        e56 = d5 - d6;
        if (va <= 0 && e43 >= 0 && e56 >= 0)
        begin
            w = q16_ratio(e43, e43 + e56);
            for (int k = 0; k < 3; k++)
                pt[k] = b[k] + (((c[k] - b[k]) * wide_t'(w)) >>> 16);
            return pack_answer(pt[0], pt[1], pt[2], p[0], p[1], p[2],
                               0, Q_ONE - w, w, cpt_pkg::REGION_BC, 0);
        end
        den = va + vb + vc;
        if (den == 0)
            return pack_answer(a[0], a[1], a[2], p[0], p[1], p[2],
                               Q_ONE, 0, 0, cpt_pkg::REGION_INTERIOR, 1);
        v = q16_ratio(vb, den);
        w = q16_ratio(vc, den);
        wa = (18'(v) + 18'(w) > 18'(Q_ONE)) ? 17'd0 : Q_ONE - v - w;
        for (int k = 0; k < 3; k++)
            pt[k] = a[k] + ((ab[k] * wide_t'(v) + ac[k] * wide_t'(w)) >>> 16);
        return pack_answer(pt[0], pt[1], pt[2], p[0], p[1], p[2],
                           wa, v, w, cpt_pkg::REGION_INTERIOR, 0);
    endfunction

    // Send one query transaction, with random gaps ahead of it
    task automatic send_query(tri_query_t t);
        while ($urandom_range(99) < send_gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        q_in <= t;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_answers.push_back(predict_nearest(t));
        sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_answers.size() != 0 && !timed_out) @(posedge clk);
    endtask

    // Result checker: compare each strobe against the oldest prediction
    always @(posedge clk)
    begin
        nearest_t got, want;
        if (rst_n && done)
        begin
            got = '{closest_x, closest_y, closest_z, weight_a, weight_b, weight_c,
                    region, dist_squared, degenerate};
            received++;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.reg_code < 7) region_hits[got.reg_code]++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d differs: expected %p actual %p",
                                 received, want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            timed_out = 1'b1;
            $display("closest_point_on_triangle_top: mismatch");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $signed($urandom);
            1: return $signed(CW'($urandom_range(0, 40 << 16))) - (20 << 16);
            default: return $signed(CW'($urandom_range(0, 2000))) - 1000;
        endcase
    endfunction

    function automatic tri_query_t rand_query();
        tri_query_t t;
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode < 8) ? 1 : 2;
        t = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
        // Flat triangles and query on a vertex now and then
        if ($urandom_range(0, 19) == 0)
        begin
            t.cx = t.bx;
            t.cy = t.by;
            t.cz = t.bz;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            t.px = t.ax;
            t.py = t.ay;
            t.pz = t.az;
        end
        return t;
    endfunction

    // Directed cases: each region, degenerate triangles, coordinate extremes
    task automatic test_directed();
        localparam logic signed [CW-1:0] ONE = 32'sh10000;
        localparam logic signed [CW-1:0] MX = 32'sh7fffffff;
        localparam logic signed [CW-1:0] MN = 32'sh80000000;
        tri_query_t t;
        t = '{0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0, -ONE, -ONE, ONE};
        send_query(t);
        t.px = 6*ONE; t.py = -ONE; send_query(t);
        t.px = 2*ONE; t.py = -ONE; send_query(t);
        t.px = -ONE; t.py = 6*ONE; send_query(t);
        t.px = -ONE; t.py = 2*ONE; send_query(t);
        t.px = 3*ONE; t.py = 3*ONE; send_query(t);
        t.px = ONE; t.py = ONE; t.pz = -5*ONE; send_query(t);
        t = '{0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE};
        send_query(t);
        t = '{0, 0, 0, 2*ONE, 0, 0, 4*ONE, 0, 0, ONE, ONE, 0};
        send_query(t);
        t = '{MX, MX, MX, MN, MN, MN, MX, MN, MX, MN, MX, MN};
        send_query(t);
        t = '{MN, MN, MN, MN, MN, MN, MN, MN, MN, MX, MX, MX};
        send_query(t);
        t = '{MN, 0, 0, MX, 0, 0, 0, MX, 0, 0, 0, MX};
        send_query(t);
        t = '{-1, -1, -1, 1, 0, 0, 0, 1, 0, 0, 0, 0};
        send_query(t);
        t = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/3, ONE/3, 0};
        send_query(t);
        t = '{MX, MN, 0, MN, MX, 0, 0, 0, MX, MX, MX, MN};
        send_query(t);
    endtask

    task automatic test_random(int count, int gap_pct);
        send_gap_pct = gap_pct;
        repeat (count) send_query(rand_query());
    endtask

    task automatic test_pause_drain();
        drain_results();
        repeat ($urandom_range(1, 40)) @(posedge clk);
        test_random(50, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        q_in = '0;
        mismatches = 0;
        sent = 0;
        received = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        send_gap_pct = 14;
        foreach (region_hits[i]) region_hits[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250, 14);
        test_pause_drain();
        test_random(200, 78);
        test_random(250, 0);

        drain_results();
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d queries, checked %0d results", sent, received);
        $display("region hits A %0d B %0d AB %0d C %0d AC %0d BC %0d inner %0d",
                 region_hits[0], region_hits[1], region_hits[2], region_hits[3],
                 region_hits[4], region_hits[5], region_hits[6]);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("closest_point_on_triangle_top: match");
        else
            $display("closest_point_on_triangle_top: mismatch");
        $finish;
    end
endmodule
